// ----- src/lswc_pkg.sv -----
// Shared types and constants of the line segment window clipper.
`default_nettype none
package lswc_pkg;

    // Region code of an endpoint: bit3 left, bit2 right, bit1 above, bit0 below
    typedef logic [3:0] t_region;

    localparam t_region RG_NONE  = 4'b0000;
    localparam int      RG_LEFT  = 3;
    localparam int      RG_RIGHT = 2;
    localparam int      RG_ABOVE = 1;
    localparam int      RG_BELOW = 0;

    // Outcome reported with every segment
    typedef enum logic [1:0] {
        VERDICT_INSIDE  = 2'd0,
        VERDICT_CLIPPED = 2'd1,
        VERDICT_REJECT  = 2'd2
    } t_verdict;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_TOP    = 2'd1,
        REG_RIGHT  = 2'd2,
        REG_BOTTOM = 2'd3
    } t_reg_idx;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

endpackage
`default_nettype wire

// ----- src/lswc_region.sv -----
// Region code of one point against the clip window.
`default_nettype none
module lswc_region
    import lswc_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic signed [COORD_BITS-1:0] i_x,
    input  wire logic signed [COORD_BITS-1:0] i_y,
    input  wire logic signed [COORD_BITS-1:0] i_left,
    input  wire logic signed [COORD_BITS-1:0] i_top,
    input  wire logic signed [COORD_BITS-1:0] i_right,
    input  wire logic signed [COORD_BITS-1:0] i_bottom,
    output t_region                           o_code
);

    // One compare per window edge
    always_comb begin
        o_code           = RG_NONE;
        o_code[RG_LEFT]  = (i_x < i_left);
        o_code[RG_RIGHT] = (i_x > i_right);
        o_code[RG_ABOVE] = (i_y < i_top);
        o_code[RG_BELOW] = (i_y > i_bottom);
    end

endmodule
`default_nettype wire

// ----- src/lswc_front.sv -----
// Input stage: registers the segment and the region codes of its endpoints.
`default_nettype none
module lswc_front
    import lswc_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic signed [COORD_BITS-1:0] i_x0,
    input  wire logic signed [COORD_BITS-1:0] i_y0,
    input  wire logic signed [COORD_BITS-1:0] i_x1,
    input  wire logic signed [COORD_BITS-1:0] i_y1,
    input  wire logic signed [COORD_BITS-1:0] i_left,
    input  wire logic signed [COORD_BITS-1:0] i_top,
    input  wire logic signed [COORD_BITS-1:0] i_right,
    input  wire logic signed [COORD_BITS-1:0] i_bottom,
    output logic                              o_valid,
    output logic signed [COORD_BITS-1:0]      o_x0,
    output logic signed [COORD_BITS-1:0]      o_y0,
    output logic signed [COORD_BITS-1:0]      o_x1,
    output logic signed [COORD_BITS-1:0]      o_y1,
    output t_region                           o_c0,
    output t_region                           o_c1
);

    t_region w_c0, w_c1;
    logic                         r_valid;
    logic signed [COORD_BITS-1:0] r_x0, r_y0, r_x1, r_y1;
    t_region                      r_c0, r_c1;

    lswc_region #(.COORD_BITS(COORD_BITS)) u_reg0 (
        .i_x(i_x0), .i_y(i_y0), .i_left(i_left), .i_top(i_top),
        .i_right(i_right), .i_bottom(i_bottom), .o_code(w_c0)
    );

    lswc_region #(.COORD_BITS(COORD_BITS)) u_reg1 (
        .i_x(i_x1), .i_y(i_y1), .i_left(i_left), .i_top(i_top),
        .i_right(i_right), .i_bottom(i_bottom), .o_code(w_c1)
    );

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0 <= i_x0;
            r_y0 <= i_y0;
            r_x1 <= i_x1;
            r_y1 <= i_y1;
            r_c0 <= w_c0;
            r_c1 <= w_c1;
        end
    end

    assign o_valid = r_valid;
    assign o_x0    = r_x0;
    assign o_y0    = r_y0;
    assign o_x1    = r_x1;
    assign o_y1    = r_y1;
    assign o_c0    = r_c0;
    assign o_c1    = r_c1;

endmodule
`default_nettype wire

// ----- src/lswc_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, side data rides along.
`default_nettype none
module lswc_div #(
    parameter int QBITS = 12,
    parameter int SIDE_BITS = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [2*QBITS-1:0]     i_num,
    input  wire logic [QBITS-1:0]       i_den,
    input  wire logic [SIDE_BITS-1:0]   i_side,
    output logic                        o_valid,
    output logic [QBITS-1:0]            o_quo,
    output logic [SIDE_BITS-1:0]        o_side
);

    localparam int NB = 2 * QBITS;

    logic                 r_v    [0:QBITS-1];
    logic [NB-1:0]        r_rem  [0:QBITS-1];
    logic [QBITS-1:0]     r_quo  [0:QBITS-1];
    logic [QBITS-1:0]     r_den  [0:QBITS-1];
    logic [SIDE_BITS-1:0] r_side [0:QBITS-1];

    // Stage k decides quotient bit QBITS-1-k
    for (genvar k = 0; k < QBITS; k++) begin : g_stage
        localparam int SH = QBITS - 1 - k;
        logic                 w_v;
        logic [NB-1:0]        w_rem;
        logic [QBITS-1:0]     w_quo;
        logic [QBITS-1:0]     w_den;
        logic [SIDE_BITS-1:0] w_side;
        logic [NB-1:0]        w_dsh;
        logic                 w_ge;
        logic [QBITS-1:0]     w_qn;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = i_num;
            assign w_quo  = '0;
            assign w_den  = i_den;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_den  = r_den[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_dsh = {{QBITS{1'b0}}, w_den} << SH;
        assign w_ge  = (w_rem >= w_dsh);
        assign w_qn  = w_quo | ({{(QBITS-1){1'b0}}, w_ge} << SH);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? (w_rem - w_dsh) : w_rem;
                r_quo[k]  <= w_qn;
                r_den[k]  <= w_den;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[QBITS-1];
    assign o_quo   = r_quo[QBITS-1];
    assign o_side  = r_side[QBITS-1];

endmodule
`default_nettype wire

// ----- src/lswc_round.sv -----
// One clipping round: pick endpoint and edge, multiply, divide, move the endpoint.
`default_nettype none
module lswc_round
    import lswc_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic signed [COORD_BITS-1:0] i_x0,
    input  wire logic signed [COORD_BITS-1:0] i_y0,
    input  wire logic signed [COORD_BITS-1:0] i_x1,
    input  wire logic signed [COORD_BITS-1:0] i_y1,
    input  wire t_region                      i_c0,
    input  wire t_region                      i_c1,
    input  wire t_region                      i_rs,
    input  wire t_region                      i_re,
    input  wire logic signed [COORD_BITS-1:0] i_left,
    input  wire logic signed [COORD_BITS-1:0] i_top,
    input  wire logic signed [COORD_BITS-1:0] i_right,
    input  wire logic signed [COORD_BITS-1:0] i_bottom,
    output logic                              o_valid,
    output logic signed [COORD_BITS-1:0]      o_x0,
    output logic signed [COORD_BITS-1:0]      o_y0,
    output logic signed [COORD_BITS-1:0]      o_x1,
    output logic signed [COORD_BITS-1:0]      o_y1,
    output t_region                           o_c0,
    output t_region                           o_c1,
    output t_region                           o_rs,
    output t_region                           o_re
);

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;          // difference width
    localparam int P  = 2 * D;          // product width
    localparam int IB = 4 * C + 16;     // segment plus four codes
    localparam int SB = IB + 3 + 2 * C + 2;

    // ---- Stage A: choose endpoint and edge, form differences
    logic                 w_act, w_first, w_vert;
    t_region              w_c;
    logic signed [C-1:0]  w_px, w_py, w_qx, w_qy, w_e, w_pi, w_pd, w_qi, w_qd;

    always_comb begin
        w_act   = !((i_c0 | i_c1) == RG_NONE || (i_c0 & i_c1) != RG_NONE);
        w_first = (i_c0 != RG_NONE);
        w_c     = w_first ? i_c0 : i_c1;
        w_px    = w_first ? i_x0 : i_x1;
        w_py    = w_first ? i_y0 : i_y1;
        w_qx    = w_first ? i_x1 : i_x0;
        w_qy    = w_first ? i_y1 : i_y0;
        w_vert  = w_c[RG_LEFT] | w_c[RG_RIGHT];
        if (w_c[RG_LEFT]) begin
            w_e = i_left;
        end else if (w_c[RG_RIGHT]) begin
            w_e = i_right;
        end else if (w_c[RG_ABOVE]) begin
            w_e = i_top;
        end else begin
            w_e = i_bottom;
        end
        w_pi = w_vert ? w_px : w_py;
        w_pd = w_vert ? w_py : w_px;
        w_qi = w_vert ? w_qx : w_qy;
        w_qd = w_vert ? w_qy : w_qx;
    end

    logic                r_a_valid, r_a_act, r_a_first, r_a_vert;
    logic [IB-1:0]       r_a_item;
    logic signed [C-1:0] r_a_e, r_a_pd;
    logic signed [D-1:0] r_a_den, r_a_dn, r_a_de;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item  <= {i_x0, i_y0, i_x1, i_y1, i_c0, i_c1, i_rs, i_re};
            r_a_act   <= w_act;
            r_a_first <= w_first;
            r_a_vert  <= w_vert;
            r_a_e     <= w_e;
            r_a_pd    <= w_pd;
            r_a_den   <= D'(w_qi) - D'(w_pi);
            r_a_dn    <= D'(w_qd) - D'(w_pd);
            r_a_de    <= D'(w_e) - D'(w_pi);
        end
    end

    // ---- Stage B: product, magnitudes and sign of the quotient
    logic signed [P-1:0] w_prod;
    logic [P-1:0]        w_pabs;
    logic [D-1:0]        w_dabs;

    assign w_prod = P'(r_a_dn) * P'(r_a_de);
    assign w_pabs = w_prod[P-1] ? (-w_prod) : w_prod;
    assign w_dabs = r_a_den[D-1] ? (-r_a_den) : r_a_den;

    logic            r_b_valid;
    logic [2*C-1:0]  r_b_num;
    logic [C-1:0]    r_b_den;
    logic [SB-1:0]   r_b_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_num  <= w_pabs[2*C-1:0];
            r_b_den  <= w_dabs[C-1:0];
            r_b_side <= {r_a_item, r_a_act, r_a_first, r_a_vert, r_a_e, r_a_pd,
                         w_prod[P-1] ^ r_a_den[D-1], (r_a_den == '0)};
        end
    end

    // ---- Divider stages
    logic           w_d_valid;
    logic [C-1:0]   w_quo;
    logic [SB-1:0]  w_side;

    lswc_div #(.QBITS(C), .SIDE_BITS(SB)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en),
        .i_valid(r_b_valid), .i_num(r_b_num), .i_den(r_b_den), .i_side(r_b_side),
        .o_valid(w_d_valid), .o_quo(w_quo), .o_side(w_side)
    );

    // ---- Stage F: add the offset, move the endpoint, recompute its code
    logic signed [C-1:0] f_x0, f_y0, f_x1, f_y1, f_e, f_pd, f_nx, f_ny;
    t_region             f_c0, f_c1, f_rs, f_re, w_ncode;
    logic                f_act, f_first, f_vert, f_neg, f_dz;
    logic signed [D-1:0] w_qs, w_sum;
    logic signed [C-1:0] w_coord;

    assign {f_x0, f_y0, f_x1, f_y1, f_c0, f_c1, f_rs, f_re,
            f_act, f_first, f_vert, f_e, f_pd, f_neg, f_dz} = w_side;

    always_comb begin
        w_qs    = f_dz ? '0 : (f_neg ? -D'(w_quo) : D'(w_quo));
        w_sum   = D'(f_pd) + w_qs;
        w_coord = w_sum[C-1:0];
        f_nx    = f_vert ? f_e : w_coord;
        f_ny    = f_vert ? w_coord : f_e;
    end

    lswc_region #(.COORD_BITS(C)) u_nreg (
        .i_x(f_nx), .i_y(f_ny), .i_left(i_left), .i_top(i_top),
        .i_right(i_right), .i_bottom(i_bottom), .o_code(w_ncode)
    );

    logic                r_f_valid;
    logic signed [C-1:0] r_x0, r_y0, r_x1, r_y1;
    t_region             r_c0, r_c1, r_rs, r_re;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (i_en) begin
            r_f_valid <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0 <= (f_act && f_first) ? f_nx : f_x0;
            r_y0 <= (f_act && f_first) ? f_ny : f_y0;
            r_c0 <= (f_act && f_first) ? w_ncode : f_c0;
            r_x1 <= (f_act && !f_first) ? f_nx : f_x1;
            r_y1 <= (f_act && !f_first) ? f_ny : f_y1;
            r_c1 <= (f_act && !f_first) ? w_ncode : f_c1;
            r_rs <= f_rs;
            r_re <= f_re;
        end
    end

    assign o_valid = r_f_valid;
    assign o_x0    = r_x0;
    assign o_y0    = r_y0;
    assign o_x1    = r_x1;
    assign o_y1    = r_y1;
    assign o_c0    = r_c0;
    assign o_c1    = r_c1;
    assign o_rs    = r_rs;
    assign o_re    = r_re;

endmodule
`default_nettype wire

// ----- src/lswc_back.sv -----
// Output stage: verdict, zeroing of rejected segments, result register.
`default_nettype none
module lswc_back
    import lswc_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic signed [COORD_BITS-1:0] i_x0,
    input  wire logic signed [COORD_BITS-1:0] i_y0,
    input  wire logic signed [COORD_BITS-1:0] i_x1,
    input  wire logic signed [COORD_BITS-1:0] i_y1,
    input  wire t_region                      i_c0,
    input  wire t_region                      i_c1,
    input  wire t_region                      i_rs,
    input  wire t_region                      i_re,
    output logic                              o_valid,
    output t_verdict                          o_verdict,
    output logic signed [COORD_BITS-1:0]      o_x0,
    output logic signed [COORD_BITS-1:0]      o_y0,
    output logic signed [COORD_BITS-1:0]      o_x1,
    output logic signed [COORD_BITS-1:0]      o_y1,
    output t_region                           o_rs,
    output t_region                           o_re
);

    t_verdict                     w_verdict;
    logic                         r_valid;
    t_verdict                     r_verdict;
    logic signed [COORD_BITS-1:0] r_x0, r_y0, r_x1, r_y1;
    t_region                      r_rs, r_re;

    // Both codes clear after the rounds means visible
    always_comb begin
        if ((i_c0 | i_c1) == RG_NONE) begin
            w_verdict = ((i_rs | i_re) == RG_NONE) ? VERDICT_INSIDE : VERDICT_CLIPPED;
        end else begin
            w_verdict = VERDICT_REJECT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_verdict <= w_verdict;
            r_x0      <= (w_verdict == VERDICT_REJECT) ? '0 : i_x0;
            r_y0      <= (w_verdict == VERDICT_REJECT) ? '0 : i_y0;
            r_x1      <= (w_verdict == VERDICT_REJECT) ? '0 : i_x1;
            r_y1      <= (w_verdict == VERDICT_REJECT) ? '0 : i_y1;
            r_rs      <= i_rs;
            r_re      <= i_re;
        end
    end

    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;
    assign o_x0      = r_x0;
    assign o_y0      = r_y0;
    assign o_x1      = r_x1;
    assign o_y1      = r_y1;
    assign o_rs      = r_rs;
    assign o_re      = r_re;

endmodule
`default_nettype wire

// ----- src/line_segment_window_clipper.sv -----
// Cohen-Sutherland line segment clipper against a programmable window.
//
// Input stream s_axis carries one segment per beat (start and end point).
// Output stream m_axis carries one result beat per segment: verdict in
// tuser, clipped endpoints and the original region codes in tdata.
// The window is set through the APB port; write it only while no segment
// is in flight. Reset loads the window 100..300 on both axes.
//
// Pipeline: one input stage, four clipping rounds of COORD_BITS+3 stages
// each (select, multiply, COORD_BITS divider stages, update), one output
// stage. A new segment is taken every cycle while m_axis is not stalled,
// as the divider in each round is pipelined at one quotient bit per stage.
// A stall on m_axis freezes the whole pipeline in place; s_axis tready
// drops until the output beat is taken, so nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty after reset.
`default_nettype none
module line_segment_window_clipper
    import lswc_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // fields from bit 0: start_x, start_y, end_x, end_y, zero fill
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // fields from bit 0: clip_start_x, clip_start_y, clip_end_x, clip_end_y,
    // start_region, end_region, zero fill
    output logic [((4*COORD_BITS+15)/8)*8-1:0] m_axis_tdata,
    // fields from bit 0: verdict
    output logic [1:0]                      m_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [APB_DATA_BITS-1:0]   pwdata,
    output logic [APB_DATA_BITS-1:0]        prdata,
    output logic                            pready
);

    localparam int C      = COORD_BITS;
    localparam int OW     = ((4 * C + 8 + 7) / 8) * 8;
    localparam int ROUNDS = 4;

    // ---- Window registers
    logic signed [C-1:0] r_left, r_top, r_right, r_bottom;
    t_reg_idx            w_idx;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= C'(100);
            r_top    <= C'(100);
            r_right  <= C'(300);
            r_bottom <= C'(300);
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_LEFT:   r_left   <= pwdata[C-1:0];
                REG_TOP:    r_top    <= pwdata[C-1:0];
                REG_RIGHT:  r_right  <= pwdata[C-1:0];
                REG_BOTTOM: r_bottom <= pwdata[C-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back, sign extended
    always_comb begin
        case (w_idx)
            REG_LEFT:   prdata = APB_DATA_BITS'(r_left);
            REG_TOP:    prdata = APB_DATA_BITS'(r_top);
            REG_RIGHT:  prdata = APB_DATA_BITS'(r_right);
            REG_BOTTOM: prdata = APB_DATA_BITS'(r_bottom);
            default:    prdata = '0;
        endcase
    end

    // ---- Global pipeline advance
    logic w_en;
    logic w_out_valid;

    assign w_en          = !w_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    // ---- Input stage
    logic                s_v  [0:ROUNDS];
    logic signed [C-1:0] s_x0 [0:ROUNDS];
    logic signed [C-1:0] s_y0 [0:ROUNDS];
    logic signed [C-1:0] s_x1 [0:ROUNDS];
    logic signed [C-1:0] s_y1 [0:ROUNDS];
    t_region             s_c0 [0:ROUNDS];
    t_region             s_c1 [0:ROUNDS];
    t_region             s_rs [0:ROUNDS];
    t_region             s_re [0:ROUNDS];

    lswc_front #(.COORD_BITS(C)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(s_axis_tvalid),
        .i_x0(s_axis_tdata[C-1:0]), .i_y0(s_axis_tdata[2*C-1:C]),
        .i_x1(s_axis_tdata[3*C-1:2*C]), .i_y1(s_axis_tdata[4*C-1:3*C]),
        .i_left(r_left), .i_top(r_top), .i_right(r_right), .i_bottom(r_bottom),
        .o_valid(s_v[0]), .o_x0(s_x0[0]), .o_y0(s_y0[0]), .o_x1(s_x1[0]),
        .o_y1(s_y1[0]), .o_c0(s_c0[0]), .o_c1(s_c1[0])
    );

    assign s_rs[0] = s_c0[0];
    assign s_re[0] = s_c1[0];

    // ---- Clipping rounds
    for (genvar r = 0; r < ROUNDS; r++) begin : g_round
        lswc_round #(.COORD_BITS(C)) u_round (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(s_v[r]),
            .i_x0(s_x0[r]), .i_y0(s_y0[r]), .i_x1(s_x1[r]), .i_y1(s_y1[r]),
            .i_c0(s_c0[r]), .i_c1(s_c1[r]), .i_rs(s_rs[r]), .i_re(s_re[r]),
            .i_left(r_left), .i_top(r_top), .i_right(r_right), .i_bottom(r_bottom),
            .o_valid(s_v[r+1]), .o_x0(s_x0[r+1]), .o_y0(s_y0[r+1]),
            .o_x1(s_x1[r+1]), .o_y1(s_y1[r+1]), .o_c0(s_c0[r+1]),
            .o_c1(s_c1[r+1]), .o_rs(s_rs[r+1]), .o_re(s_re[r+1])
        );
    end

    // ---- Output stage
    t_verdict            w_verdict;
    logic signed [C-1:0] w_ox0, w_oy0, w_ox1, w_oy1;
    t_region             w_ors, w_ore;

    lswc_back #(.COORD_BITS(C)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(s_v[ROUNDS]),
        .i_x0(s_x0[ROUNDS]), .i_y0(s_y0[ROUNDS]), .i_x1(s_x1[ROUNDS]),
        .i_y1(s_y1[ROUNDS]), .i_c0(s_c0[ROUNDS]), .i_c1(s_c1[ROUNDS]),
        .i_rs(s_rs[ROUNDS]), .i_re(s_re[ROUNDS]),
        .o_valid(w_out_valid), .o_verdict(w_verdict), .o_x0(w_ox0), .o_y0(w_oy0),
        .o_x1(w_ox1), .o_y1(w_oy1), .o_rs(w_ors), .o_re(w_ore)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tuser  = w_verdict;
    assign m_axis_tdata  = OW'({w_ore, w_ors, w_oy1, w_ox1, w_oy0, w_ox0});

endmodule
`default_nettype wire
